// ----- sv/mfec_pkg.sv -----
// Shared types and codes for the multi-format element comparator.
package mfec_pkg;

  localparam logic [2:0] OP_EQ = 3'd0;
  localparam logic [2:0] OP_NE = 3'd1;
  localparam logic [2:0] OP_LT = 3'd2;
  localparam logic [2:0] OP_LE = 3'd3;
  localparam logic [2:0] OP_GT = 3'd4;
  localparam logic [2:0] OP_GE = 3'd5;

  localparam logic [2:0] TY_F32  = 3'd0;
  localparam logic [2:0] TY_F64  = 3'd1;
  localparam logic [2:0] TY_I32  = 3'd2;
  localparam logic [2:0] TY_I64  = 3'd3;
  localparam logic [2:0] TY_BOOL = 3'd4;
  localparam logic [2:0] TY_F16  = 3'd5;
  localparam logic [2:0] TY_BF16 = 3'd6;

  localparam logic [1:0] CFG_OP     = 2'd0;
  localparam logic [1:0] CFG_TYPE   = 2'd1;
  localparam logic [1:0] CFG_SCALAR = 2'd2;
  localparam logic [1:0] CFG_SVAL   = 2'd3;

  localparam logic [1:0] REL_LT = 2'd0;
  localparam logic [1:0] REL_EQ = 2'd1;
  localparam logic [1:0] REL_GT = 2'd2;
  localparam logic [1:0] REL_UN = 2'd3;

  typedef struct packed {
    logic [63:0] left_bits;
    logic [63:0] right_bits;
    logic        final_in;
  } in_item_t;

  typedef struct packed {
    logic verdict;
    logic unsupported;
    logic final_out;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  compare_op;
    logic [2:0]  element_type;
    logic        use_scalar;
    logic [63:0] scalar_value;
  } cfg_t;

endpackage

// ----- sv/mfec_eval.sv -----
// Combinational relation and predicate evaluation for one operand pair.
module mfec_eval (
  input  mfec_pkg::cfg_t      cfg,
  input  mfec_pkg::in_item_t  item,
  output mfec_pkg::out_item_t res
);
  import mfec_pkg::*;

  logic [63:0] a, b, ma, mb, inf, ka, kb;
  logic        sa, sb, is_float, ok;
  logic [1:0]  rel;

  always_comb begin
    a = item.left_bits;
    b = cfg.use_scalar ? cfg.scalar_value : item.right_bits;
    ma = '0; mb = '0; inf = '0; sa = 1'b0; sb = 1'b0;
    ka = '0; kb = '0;
    is_float = 1'b0;
    ok = 1'b1;
    rel = REL_UN;
    unique case (cfg.element_type)
      TY_F32: begin
        is_float = 1'b1;
        ma = {33'd0, a[30:0]}; mb = {33'd0, b[30:0]};
        sa = a[31]; sb = b[31]; inf = 64'h7F80_0000;
      end
      TY_F64: begin
        is_float = 1'b1;
        ma = {1'b0, a[62:0]}; mb = {1'b0, b[62:0]};
        sa = a[63]; sb = b[63]; inf = 64'h7FF0_0000_0000_0000;
      end
      TY_F16: begin
        is_float = 1'b1;
        ma = {49'd0, a[14:0]}; mb = {49'd0, b[14:0]};
        sa = a[15]; sb = b[15]; inf = 64'h7C00;
      end
      TY_BF16: begin
        is_float = 1'b1;
        ma = {49'd0, a[14:0]}; mb = {49'd0, b[14:0]};
        sa = a[15]; sb = b[15]; inf = 64'h7F80;
      end
      TY_I32: begin
        ka = {32'd0, ~a[31], a[30:0]}; kb = {32'd0, ~b[31], b[30:0]};
      end
      TY_I64: begin
        ka = {~a[63], a[62:0]}; kb = {~b[63], b[62:0]};
      end
      TY_BOOL: begin
        ok = (cfg.compare_op == OP_EQ) || (cfg.compare_op == OP_NE);
      end
      default: ok = 1'b0;
    endcase

    if (is_float) begin
      priority if (ma > inf || mb > inf) rel = REL_UN;
      else if (ma == '0 && mb == '0) rel = REL_EQ;
      else if (sa != sb) rel = sa ? REL_LT : REL_GT;
      else if (ma == mb) rel = REL_EQ;
      else if (!sa) rel = (ma < mb) ? REL_LT : REL_GT;
      else rel = (ma > mb) ? REL_LT : REL_GT;
    end else if (cfg.element_type == TY_BOOL) begin
      rel = (a[0] == b[0]) ? REL_EQ : REL_LT;
    end else begin
      rel = (ka == kb) ? REL_EQ : ((ka < kb) ? REL_LT : REL_GT);
    end

    res.final_out = item.final_in;
    res.verdict = 1'b0;
    res.unsupported = 1'b0;
    if (!ok) begin
      res.unsupported = 1'b1;
    end else begin
      unique case (cfg.compare_op)
        OP_EQ: res.verdict = (rel == REL_EQ);
        OP_NE: res.verdict = (rel != REL_EQ);
        OP_LT: res.verdict = (rel == REL_LT);
        OP_LE: res.verdict = (rel == REL_LT) || (rel == REL_EQ);
        OP_GT: res.verdict = (rel == REL_GT);
        OP_GE: res.verdict = (rel == REL_GT) || (rel == REL_EQ);
        default: res.unsupported = 1'b1;
      endcase
    end
  end
endmodule

// ----- sv/multi_format_element_comparator_top.sv -----
// Top level of the multi-format element comparator.
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while out_ready holds; the compare itself is one pass of combinational logic.
// Either stage advances whenever its downstream slot is empty or being drained.
// Reset clears both stage valid flags and all configuration registers to zero.
module multi_format_element_comparator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mfec_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mfec_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import mfec_pkg::*;

  cfg_t      cfg;
  in_item_t  stage_item;
  logic      stage_valid;
  out_item_t res_item;
  out_item_t eval_res;
  logic      res_valid;
  logic      res_take;
  logic      stage_take;

  // Configuration: plain writes, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OP:     cfg.compare_op   <= cfg_data[2:0];
        CFG_TYPE:   cfg.element_type <= cfg_data[2:0];
        CFG_SCALAR: cfg.use_scalar   <= cfg_data[0];
        CFG_SVAL:   cfg.scalar_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result slot frees when empty or being taken; input slot moves into it.
  assign res_take   = !res_valid || out_ready;
  assign stage_take = !stage_valid || res_take;
  assign in_ready   = stage_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_take) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take && in_valid) begin
      stage_item <= in_data;
    end
  end

  mfec_eval u_eval (
    .cfg  (cfg),
    .item (stage_item),
    .res  (eval_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_take) begin
      res_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && stage_valid) begin
      res_item <= eval_res;
    end
  end

  assign out_valid = res_valid;
  assign out_data  = res_item;
endmodule

// ----- dv/tb.sv -----
// Self-checking bench for the multi-format element comparator top level.
module tb;
  import mfec_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  multi_format_element_comparator_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Watchdog limit in cycles with no item moving on either side.
  localparam int STALL_LIMIT = 2000;

  // Shadow of the configuration registers.
  logic [2:0]  sh_op;
  logic [2:0]  sh_type;
  logic        sh_scalar;
  logic [63:0] sh_sval;

  in_item_t  pending_items[$];
  out_item_t expected_verdicts[$];
  int        error_count;
  bit        quiet_tail;   // no idling once set
  int        send_gap;
  int        recv_gap;
  int        idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report(input string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  // Order two IEEE words of the given width and exponent size.
  function automatic logic [1:0] ieee_order(input logic [63:0] a, input logic [63:0] b,
                                            input int width, input int expbits);
    logic [63:0] word;
    logic [63:0] mag;
    logic [63:0] inf;
    logic [63:0] ma;
    logic [63:0] mb;
    logic        sa;
    logic        sb;
    word = (width == 64) ? '1 : ((64'd1 << width) - 1);
    mag  = (64'd1 << (width - 1)) - 1;
    inf  = ((64'd1 << expbits) - 1) << (width - 1 - expbits);
    a &= word;
    b &= word;
    ma = a & mag;
    mb = b & mag;
    sa = a[width-1];
    sb = b[width-1];
    // NaN on either side makes the pair unordered
    if (ma > inf || mb > inf) return REL_UN;
    // plus and minus zero are equal
    if (ma == 0 && mb == 0) return REL_EQ;
    if (sa != sb) return sa ? REL_LT : REL_GT;
    if (ma == mb) return REL_EQ;
    if (!sa) return (ma < mb) ? REL_LT : REL_GT;
    return (ma > mb) ? REL_LT : REL_GT;
  endfunction

  function automatic logic [1:0] twos_order(input logic [63:0] a, input logic [63:0] b,
                                            input int width);
    logic [63:0] word;
    logic [63:0] flip;
    logic [63:0] ka;
    logic [63:0] kb;
    word = (width == 64) ? '1 : ((64'd1 << width) - 1);
    flip = 64'd1 << (width - 1);
    ka = (a & word) ^ flip;
    kb = (b & word) ^ flip;
    if (ka == kb) return REL_EQ;
    return (ka < kb) ? REL_LT : REL_GT;
  endfunction

  // Work out the verdict for one item under the shadow configuration.
  function automatic out_item_t compare_verdict(input in_item_t it);
    out_item_t   r;
    logic [63:0] b;
    logic [1:0]  rel;
    bit          ok;
    b   = sh_scalar ? sh_sval : it.right_bits;
    rel = REL_UN;
    ok  = 1;
    r   = '0;
    case (sh_type)
      TY_F32:  rel = ieee_order(it.left_bits, b, 32, 8);
      TY_F64:  rel = ieee_order(it.left_bits, b, 64, 11);
      TY_I32:  rel = twos_order(it.left_bits, b, 32);
      TY_I64:  rel = twos_order(it.left_bits, b, 64);
      TY_BOOL: begin
        if (sh_op >= OP_LT) ok = 0;
        else rel = (it.left_bits[0] == b[0]) ? REL_EQ : REL_LT;
      end
      TY_F16:  rel = ieee_order(it.left_bits, b, 16, 5);
      TY_BF16: rel = ieee_order(it.left_bits, b, 16, 8);
      default: ok = 0;
    endcase
    if (ok) begin
      case (sh_op)
        OP_EQ:   r.verdict = (rel == REL_EQ);
        OP_NE:   r.verdict = (rel != REL_EQ);
        OP_LT:   r.verdict = (rel == REL_LT);
        OP_LE:   r.verdict = (rel == REL_LT || rel == REL_EQ);
        OP_GT:   r.verdict = (rel == REL_GT);
        OP_GE:   r.verdict = (rel == REL_GT || rel == REL_EQ);
        default: r.unsupported = 1'b1;
      endcase
    end else begin
      r.unsupported = 1'b1;
    end
    r.final_out = it.final_in;
    return r;
  endfunction

  // Pick an operand word biased toward the interesting encodings of the type.
  function automatic logic [63:0] pick_operand(input logic [2:0] ty);
    logic [63:0] w;
    int          width;
    int          expbits;
    int          sel;
    w = {$urandom, $urandom};
    width = 32;
    expbits = 8;
    case (ty)
      TY_F64: begin width = 64; expbits = 11; end
      TY_F16: begin width = 16; expbits = 5; end
      TY_BF16: begin width = 16; expbits = 8; end
      default: ;
    endcase
    sel = $urandom_range(0, 9);
    if (ty == TY_I32 || ty == TY_I64 || ty == TY_BOOL) begin
      if (sel < 3) w = {$urandom, $urandom} & 64'h3;
      else if (sel < 5) w = '1 ^ (64'($urandom_range(0, 3)));
      return w;
    end
    case (sel)
      // zero of either sign, keep random upper garbage
      0: begin w &= ~((64'd1 << (width - 1)) - 1); end
      // infinity
      1: begin w &= ~((64'd1 << (width - 1)) - 1);
               w |= ((64'd1 << expbits) - 1) << (width - 1 - expbits); end
      // NaN
      2: begin w |= ((64'd1 << expbits) - 1) << (width - 1 - expbits);
               w[0] = 1'b1; end
      // small exponent range so many pairs land close together
      3, 4: begin w &= ~(((64'd1 << expbits) - 1) << (width - 1 - expbits));
                  w |= 64'($urandom_range(0, 3)) << (width - expbits); end
      default: ;
    endcase
    return w;
  endfunction

  task automatic wait_clocks(input int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Hold until every queued item has been sent and answered, plus pipeline slack.
  task automatic drain;
    while (pending_items.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    wait_clocks(4);
  endtask

  task automatic configure(input logic [2:0] op, input logic [2:0] ty,
                           input logic sc, input logic [63:0] sv);
    write_reg(CFG_OP, 64'(op));
    write_reg(CFG_TYPE, 64'(ty));
    write_reg(CFG_SCALAR, 64'(sc));
    write_reg(CFG_SVAL, sv);
  endtask

  // Queue one phase of random items under the configuration just written.
  task automatic queue_phase(input int n, input logic [2:0] ty);
    in_item_t it;
    repeat (n) begin
      it.left_bits  = pick_operand(ty);
      it.right_bits = ($urandom_range(0, 3) == 0) ? it.left_bits : pick_operand(ty);
      it.final_in   = 1'($urandom_range(0, 1));
      pending_items.insert(pending_items.size(), it);
    end
  endtask

  // Driver: present the head of the queue, hold it until accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_verdicts.insert(expected_verdicts.size(), compare_verdict(in_data));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_items.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
          if (!quiet_tail && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data.verdict !== want.verdict)
            report($sformatf("verdict got %b want %b", out_data.verdict, want.verdict));
          if (out_data.unsupported !== want.unsupported)
            report($sformatf("unsupported got %b want %b",
                             out_data.unsupported, want.unsupported));
          if (out_data.final_out !== want.final_out)
            report($sformatf("final_out got %b want %b", out_data.final_out, want.final_out));
        end
      end
      if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap  <= recv_gap - 1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        recv_gap  <= $urandom_range(0, 7);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles with no accept on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (pending_items.size() != 0 || in_valid || expected_verdicts.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    in_item_t it;
    logic [2:0] ops[8];
    logic [2:0] tys[8];
    int         p;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_OP;
    cfg_data   = '0;
    quiet_tail = 0;
    error_count = 0;
    idle_cycles = 0;
    send_gap = 0;
    recv_gap = 0;
    sh_op = OP_EQ; sh_type = TY_F32; sh_scalar = 0; sh_sval = '0;
    wait_clocks(2);
    rst <= 1'b0;

    // Directed: reset configuration (f32 eq), signed zeros, NaN, extremes.
    it = '{left_bits: 64'h0000_0000_8000_0000, right_bits: 64'h0, final_in: 1'b1};
    pending_items.insert(pending_items.size(), it);
    it = '{left_bits: 64'h7FC0_0000, right_bits: 64'h7FC0_0000, final_in: 1'b0};
    pending_items.insert(pending_items.size(), it);
    it = '{left_bits: '1, right_bits: '0, final_in: 1'b1};
    pending_items.insert(pending_items.size(), it);
    drain();

    // Directed: every predicate and every type code, including the unused ones.
    ops = '{OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE, 3'd6, 3'd7};
    tys = '{TY_F32, TY_F64, TY_I32, TY_I64, TY_BOOL, TY_F16, TY_BF16, 3'd7};
    foreach (ops[i]) begin
      configure(ops[i], tys[i], i[0], {$urandom, $urandom});
      sh_op = ops[i]; sh_type = tys[i]; sh_scalar = i[0];
      // the scalar register keeps the whole word last written
      sh_sval = cfg_data;
      it = '{left_bits: 64'h8000_0000_0000_0000, right_bits: 64'h7FFF_FFFF_FFFF_FFFF,
             final_in: i[1]};
      pending_items.insert(pending_items.size(), it);
      it.left_bits = '0; it.right_bits = 64'h1;
      pending_items.insert(pending_items.size(), it);
      drain();
    end

    // Random phases: each a fresh setting, most with valid predicate and type.
    for (p = 0; p < 40; p++) begin
      sh_op     = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
      sh_type   = ($urandom_range(0, 14) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
      sh_scalar = 1'($urandom_range(0, 1));
      sh_sval   = pick_operand(sh_type);
      configure(sh_op, sh_type, sh_scalar, sh_sval);
      if (p >= 34) quiet_tail = 1;
      queue_phase(18, sh_type);
      drain();
    end

    wait_clocks(10);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
